// ===== hdl/cache_query_request_parser_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the cache query request parser
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CACHE_QUERY_REQUEST_PARSER_MACROS_SVH
`define CACHE_QUERY_REQUEST_PARSER_MACROS_SVH

// same-cycle implication
`define CQRP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CQRP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/cqrp_pkg.sv =====
// ----------------------------------------------------------------------------
// Cache query request parser package
// Field codes, status codes, phase type and shared structs.
// ----------------------------------------------------------------------------
package cqrp_pkg;

  localparam int DIGEST_BYTES = 32;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_DATA  = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  localparam logic [1:0] ST_PROGRESS   = 2'd0;
  localparam logic [1:0] ST_COMPLETE   = 2'd1;
  localparam logic [1:0] ST_MALFORMED  = 2'd2;
  localparam logic [1:0] ST_INCOMPLETE = 2'd3;

  localparam logic [2:0] KIND_NONE     = 3'd0;
  localparam logic [2:0] KIND_PREFIX   = 3'd1;
  localparam logic [2:0] KIND_DIGEST   = 3'd2;
  localparam logic [2:0] KIND_KEY_LEN  = 3'd3;
  localparam logic [2:0] KIND_KEY      = 3'd4;
  localparam logic [2:0] KIND_HDR_LEN  = 3'd5;
  localparam logic [2:0] KIND_HDR      = 3'd6;
  localparam logic [2:0] KIND_TRAILING = 3'd7;

  localparam logic [2:0] REG_MAGIC_FIRST     = 3'd0;
  localparam logic [2:0] REG_MAGIC_SECOND    = 3'd1;
  localparam logic [2:0] REG_VERSION_VALUE   = 3'd2;
  localparam logic [2:0] REG_GET_OPCODE      = 3'd3;
  localparam logic [2:0] REG_KEY_CAPACITY    = 3'd4;
  localparam logic [2:0] REG_HEADER_CAPACITY = 3'd5;

  typedef enum logic [2:0] {
    PH_PREFIX,
    PH_DIGEST,
    PH_KLEN,
    PH_KEY,
    PH_HLEN,
    PH_HDR,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0]  magic_first;
    logic [7:0]  magic_second;
    logic [7:0]  version_value;
    logic [7:0]  get_opcode;
    logic [15:0] key_capacity;
    logic [15:0] header_capacity;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  field_kind;
    logic [15:0] field_offset;
    logic [7:0]  payload_byte;
    logic [15:0] key_length;
    logic [15:0] header_length;
  } res_t;

endpackage

// ===== hdl/cqrp_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Configuration register file
// Holds the expected prefix bytes and the key and header capacities.
// ----------------------------------------------------------------------------
module cqrp_cfg_regs (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [2:0]       wr_index,
  input  logic [15:0]      wr_data,
  output cqrp_pkg::cfg_t   cfg
);
  import cqrp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.magic_first     <= 8'd0;
      cfg.magic_second    <= 8'd0;
      cfg.version_value   <= 8'd1;
      cfg.get_opcode      <= 8'd1;
      cfg.key_capacity    <= 16'd256;
      cfg.header_capacity <= 16'd1024;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_MAGIC_FIRST:     cfg.magic_first     <= wr_data[7:0];
        REG_MAGIC_SECOND:    cfg.magic_second    <= wr_data[7:0];
        REG_VERSION_VALUE:   cfg.version_value   <= wr_data[7:0];
        REG_GET_OPCODE:      cfg.get_opcode      <= wr_data[7:0];
        REG_KEY_CAPACITY:    cfg.key_capacity    <= wr_data;
        REG_HEADER_CAPACITY: cfg.header_capacity <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/cqrp_parse_core.sv =====
// ----------------------------------------------------------------------------
// Frame parse core
// Frame state and the single-pass step that labels one item.
// ----------------------------------------------------------------------------
module cqrp_parse_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [1:0]       op,
  input  logic [7:0]       data_byte,
  input  cqrp_pkg::cfg_t   cfg,
  output cqrp_pkg::res_t   res
);
  import cqrp_pkg::*;

  phase_t      phase, phase_next;
  logic [15:0] phase_count, phase_count_next;
  logic [15:0] key_len, key_len_next;
  logic [15:0] hdr_len, hdr_len_next;
  logic [7:0]  low_byte, low_byte_next;
  logic [1:0]  frame_status, frame_status_next;

  logic [16:0] off_inc;
  logic [15:0] len_word;
  logic [7:0]  expected;

  assign off_inc  = {1'b0, phase_count} + 17'd1;
  assign len_word = {data_byte, low_byte};

  always_comb begin
    if (phase_count == 16'd0)      expected = cfg.magic_first;
    else if (phase_count == 16'd1) expected = cfg.magic_second;
    else if (phase_count == 16'd2) expected = cfg.version_value;
    else                           expected = cfg.get_opcode;
  end

  // next state
  always_comb begin
    phase_next        = phase;
    phase_count_next  = phase_count;
    key_len_next      = key_len;
    hdr_len_next      = hdr_len;
    low_byte_next     = low_byte;
    frame_status_next = frame_status;
    unique case (op)
      OP_START: begin
        phase_next        = PH_PREFIX;
        phase_count_next  = 16'd0;
        key_len_next      = 16'd0;
        hdr_len_next      = 16'd0;
        low_byte_next     = 8'd0;
        frame_status_next = ST_PROGRESS;
      end
      OP_DATA: begin
        if (frame_status != ST_MALFORMED) begin
          unique case (phase)
            PH_PREFIX: begin
              if (data_byte != expected) begin
                frame_status_next = ST_MALFORMED;
              end else if (phase_count >= 16'd3) begin
                phase_next       = PH_DIGEST;
                phase_count_next = 16'd0;
              end else begin
                phase_count_next = off_inc[15:0];
              end
            end
            PH_DIGEST: begin
              if (off_inc >= 17'(DIGEST_BYTES)) begin
                phase_next       = PH_KLEN;
                phase_count_next = 16'd0;
              end else begin
                phase_count_next = off_inc[15:0];
              end
            end
            PH_KLEN: begin
              if (phase_count == 16'd0) begin
                low_byte_next    = data_byte;
                phase_count_next = 16'd1;
              end else begin
                key_len_next = len_word;
                if (len_word >= cfg.key_capacity) begin
                  frame_status_next = ST_MALFORMED;
                end else begin
                  phase_next       = (len_word == 16'd0) ? PH_HLEN : PH_KEY;
                  phase_count_next = 16'd0;
                end
              end
            end
            PH_KEY: begin
              if (off_inc >= {1'b0, key_len}) begin
                phase_next       = PH_HLEN;
                phase_count_next = 16'd0;
              end else begin
                phase_count_next = off_inc[15:0];
              end
            end
            PH_HLEN: begin
              if (phase_count == 16'd0) begin
                low_byte_next    = data_byte;
                phase_count_next = 16'd1;
              end else begin
                hdr_len_next = len_word;
                if (len_word >= cfg.header_capacity) begin
                  frame_status_next = ST_MALFORMED;
                end else if (len_word == 16'd0) begin
                  phase_next        = PH_DONE;
                  phase_count_next  = 16'd0;
                  frame_status_next = ST_COMPLETE;
                end else begin
                  phase_next       = PH_HDR;
                  phase_count_next = 16'd0;
                end
              end
            end
            PH_HDR: begin
              if (off_inc >= {1'b0, hdr_len}) begin
                phase_next        = PH_DONE;
                phase_count_next  = 16'd0;
                frame_status_next = ST_COMPLETE;
              end else begin
                phase_count_next = off_inc[15:0];
              end
            end
            default: begin
              if (phase_count != 16'hFFFF) phase_count_next = off_inc[15:0];
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  // result
  always_comb begin
    res.status        = frame_status;
    res.field_kind    = KIND_NONE;
    res.field_offset  = 16'd0;
    res.payload_byte  = 8'd0;
    res.key_length    = key_len_next;
    res.header_length = hdr_len_next;
    unique case (op)
      OP_START: res.status = frame_status_next;
      OP_DATA: begin
        res.status = frame_status_next;
        if (frame_status != ST_MALFORMED) begin
          res.field_offset = phase_count;
          unique case (phase)
            PH_PREFIX: res.field_kind = KIND_PREFIX;
            PH_DIGEST: begin
              res.field_kind   = KIND_DIGEST;
              res.payload_byte = data_byte;
            end
            PH_KLEN:   res.field_kind = KIND_KEY_LEN;
            PH_KEY: begin
              res.field_kind   = KIND_KEY;
              res.payload_byte = data_byte;
            end
            PH_HLEN:   res.field_kind = KIND_HDR_LEN;
            PH_HDR: begin
              res.field_kind   = KIND_HDR;
              res.payload_byte = data_byte;
            end
            default: begin
              res.field_kind = KIND_TRAILING;
              res.status     = ST_COMPLETE;
            end
          endcase
        end
      end
      OP_END: res.status = (frame_status == ST_PROGRESS) ? ST_INCOMPLETE : frame_status;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_PREFIX;
      phase_count  <= 16'd0;
      key_len      <= 16'd0;
      hdr_len      <= 16'd0;
      low_byte     <= 8'd0;
      frame_status <= ST_PROGRESS;
    end else if (step) begin
      phase        <= phase_next;
      phase_count  <= phase_count_next;
      key_len      <= key_len_next;
      hdr_len      <= hdr_len_next;
      low_byte     <= low_byte_next;
      frame_status <= frame_status_next;
    end
  end

endmodule

// ===== hdl/cache_query_request_parser.sv =====
// ----------------------------------------------------------------------------
// Cache query request parser
// Byte-serial deframer that labels each byte of a peer cache query request.
// ----------------------------------------------------------------------------
// One item enters per cycle and gives one result item. An item is held in
// the input register, where the prefix compare, the length checks and the
// field counter update are worked out in a single pass, and then moves to
// the result register. The sustained rate is one item per cycle while the
// result side keeps taking items. The
// configuration port is always ready; write it only while the block is idle.
`include "cache_query_request_parser_macros.svh"

module cache_query_request_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [2:0]  field_kind,
  output logic [15:0] field_offset,
  output logic [7:0]  payload_byte,
  output logic [15:0] key_length,
  output logic [15:0] header_length
);
  import cqrp_pkg::*;

  cfg_t       cfg;
  res_t       res;
  logic       in_held;
  logic [1:0] in_op;
  logic [7:0] in_byte;
  logic       advance;

  assign cfg_ready = 1'b1;
  assign advance   = in_held && (!out_valid || out_ready);
  assign in_ready  = !in_held || advance;

  cqrp_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  cqrp_parse_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .op        (in_op),
    .data_byte (in_byte),
    .cfg       (cfg),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_held <= 1'b0;
    end else if (in_ready) begin
      in_held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_op   <= op;
      in_byte <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status        <= res.status;
      field_kind    <= res.field_kind;
      field_offset  <= res.field_offset;
      payload_byte  <= res.payload_byte;
      key_length    <= res.key_length;
      header_length <= res.header_length;
    end
  end

  `CQRP_ASSERT_NEXT(a_pass_loads_result, advance, out_valid, "pass did not load result")
  `CQRP_ASSERT_NOW(a_full_stall_blocks, in_held && out_valid && !out_ready, !in_ready,
    "input taken while both registers full")
  `CQRP_ASSERT_NOW(a_trailing_complete, out_valid && field_kind == KIND_TRAILING,
    status == ST_COMPLETE, "trailing byte without complete status")
  `CQRP_ASSERT_NOW(a_no_payload_leak,
    out_valid && (field_kind == KIND_NONE || field_kind == KIND_PREFIX ||
    field_kind == KIND_KEY_LEN || field_kind == KIND_HDR_LEN ||
    field_kind == KIND_TRAILING), payload_byte == 8'd0, "payload on non-payload field")

endmodule
